[src/ctsfb_pkg.sv]
// ----------------------------------------------------------------------------
// ctsfb_pkg
// Shared constants and types of the change-triggered sensor frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package ctsfb_pkg;

	// number of 16-bit readings checked side by side
	localparam int NUM_LANES = 4;

	// CRC-16 (reflected, init all ones)
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// group type bytes
	localparam logic [7:0] TYPE_INTEGER = 8'h02;
	localparam logic [7:0] TYPE_BOOLEAN = 8'h01;

	// percent scale of the change test
	localparam int PERCENT_SCALE = 100;

	// configuration register indexes
	localparam logic [1:0] REG_NODE_ID  = 2'd0;
	localparam logic [1:0] REG_DELTA    = 2'd1;
	localparam logic [1:0] REG_INTERVAL = 2'd2;

	localparam logic [15:0] INTERVAL_RESET = 16'd15;

	// contents of one report frame, handed to the framer
	typedef struct packed {
		logic [7:0]                  node_id;
		logic [NUM_LANES-1:0][15:0] values;
		logic                        digital_input;
		logic                        motion_value;
		logic                        motion_valid;
		logic                        vibration_value;
	} frame_req_t;

endpackage

`default_nettype wire

[src/ctsfb_lane.sv]
// ----------------------------------------------------------------------------
// ctsfb_lane
// One reading channel: keeps the reference and tests the percent change.
// ----------------------------------------------------------------------------
`default_nettype none

module ctsfb_lane (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        calc,        // current reading is valid, form products
	input  wire logic        commit,      // decision cycle, update the reference
	input  wire logic        load_first,  // first item: reference taken from reading
	input  wire logic [3:0]  delta,
	input  wire logic [15:0] cur,
	output logic             changed
);

	logic [15:0] ref_q;
	logic [15:0] eff_ref;
	logic [15:0] diff;
	logic [22:0] lhs_c;
	logic [20:0] rhs_c;
	logic [22:0] lhs_s1;
	logic [20:0] rhs_s1;
	logic        zero_s1;

	// |pct| > d  <=>  |ref-cur|*100 >= (d+1)*cur, cur nonzero
	assign eff_ref = load_first ? cur : ref_q;
	assign diff    = (eff_ref >= cur) ? (eff_ref - cur) : (cur - eff_ref);
	assign lhs_c   = 23'(diff) * 23'(ctsfb_pkg::PERCENT_SCALE);
	assign rhs_c   = 21'({1'b0, delta} + 5'd1) * 21'(cur);

	// product registers
	always_ff @(posedge clk) begin
		if (calc) begin
			lhs_s1  <= lhs_c;
			rhs_s1  <= rhs_c;
			zero_s1 <= (cur == 16'd0);
		end
	end

	assign changed = (delta != 4'd0) && (zero_s1 || (lhs_s1 >= {2'b00, rhs_s1}));

	// reference update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= 16'd0;
		end else if (commit && (load_first || changed)) begin
			ref_q <= cur;
		end
	end

endmodule

`default_nettype wire

[src/ctsfb_framer.sv]
// ----------------------------------------------------------------------------
// ctsfb_framer
// Serializes one report frame byte by byte and appends the CRC.
// ----------------------------------------------------------------------------
`default_nettype none

module ctsfb_framer (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire ctsfb_pkg::frame_req_t req,
	output logic                       busy,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [7:0]                 m_tdata,   // [7:0] frame_byte
	output logic                       m_tlast    // frame_last
);

	localparam logic [1:0] PH_ID     = 2'd0;
	localparam logic [1:0] PH_GROUP  = 2'd1;
	localparam logic [1:0] PH_CRC_HI = 2'd2;
	localparam logic [1:0] PH_CRC_LO = 2'd3;

	localparam logic [2:0] GRP_DIGITAL = 3'd4;
	localparam logic [2:0] GRP_MOTION  = 3'd5;
	localparam logic [2:0] GRP_VIB     = 3'd6;
	localparam logic [2:0] SUB_LAST    = 3'd4;

	ctsfb_pkg::frame_req_t req_q;
	logic [1:0]  phase_q;
	logic [2:0]  group_q;
	logic [2:0]  sub_q;
	logic [15:0] crc_q;
	logic        busy_q;
	logic        valid_q;
	logic [7:0]  data_q;
	logic        last_q;

	logic        advance;
	logic [7:0]  byte_c;
	logic [15:0] value_c;
	logic [7:0]  type_c;
	logic        is_data;

	function automatic logic [15:0] crc_feed(input logic [15:0] c_in, input logic [7:0] b);
		logic [15:0] c;
		c = c_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ ctsfb_pkg::CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	assign advance = busy_q && (!valid_q || m_tready);

	// group value and type
	always_comb begin
		if (group_q < GRP_DIGITAL) begin
			value_c = req_q.values[group_q[1:0]];
			type_c  = ctsfb_pkg::TYPE_INTEGER;
		end else begin
			type_c = ctsfb_pkg::TYPE_BOOLEAN;
			unique case (group_q)
				GRP_DIGITAL: value_c = {15'd0, req_q.digital_input};
				GRP_MOTION:  value_c = {15'd0, req_q.motion_value};
				default:     value_c = {15'd0, req_q.vibration_value};
			endcase
		end
	end

	// byte select
	always_comb begin
		is_data = 1'b0;
		byte_c  = 8'h00;
		unique case (phase_q)
			PH_ID: begin
				is_data = 1'b1;
				byte_c  = req_q.node_id;
			end
			PH_GROUP: begin
				is_data = 1'b1;
				unique case (sub_q)
					3'd0:    byte_c = 8'h00;
					3'd1:    byte_c = {5'd0, group_q} + 8'd1;
					3'd2:    byte_c = value_c[15:8];
					3'd3:    byte_c = value_c[7:0];
					default: byte_c = type_c;
				endcase
			end
			PH_CRC_HI: byte_c = crc_q[15:8];
			default:   byte_c = crc_q[7:0];
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= PH_ID;
			group_q <= 3'd0;
			sub_q   <= 3'd0;
			crc_q   <= ctsfb_pkg::CRC_INIT;
		end else if (start) begin
			busy_q  <= 1'b1;
			phase_q <= PH_ID;
			group_q <= 3'd0;
			sub_q   <= 3'd0;
			crc_q   <= ctsfb_pkg::CRC_INIT;
		end else if (advance) begin
			if (is_data) begin
				crc_q <= crc_feed(crc_q, byte_c);
			end
			unique case (phase_q)
				PH_ID: phase_q <= PH_GROUP;
				PH_GROUP: begin
					if (sub_q == SUB_LAST) begin
						sub_q <= 3'd0;
						if (group_q == GRP_VIB) begin
							phase_q <= PH_CRC_HI;
						end else if (group_q == GRP_DIGITAL && !req_q.motion_valid) begin
							group_q <= GRP_VIB;  // motion group left out
						end else begin
							group_q <= group_q + 3'd1;
						end
					end else begin
						sub_q <= sub_q + 3'd1;
					end
				end
				PH_CRC_HI: phase_q <= PH_CRC_LO;
				default: begin
					busy_q <= 1'b0;
					crc_q  <= ctsfb_pkg::CRC_INIT;
				end
			endcase
		end
	end

	// request payload capture
	always_ff @(posedge clk) begin
		if (start) begin
			req_q <= req;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_q <= byte_c;
			last_q <= (phase_q == PH_CRC_LO);
		end
	end

	assign busy     = busy_q;
	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;

endmodule

`default_nettype wire

[src/change_triggered_sensor_frame_builder.sv]
// ----------------------------------------------------------------------------
// change_triggered_sensor_frame_builder
// Compares four readings against stored references in parallel lanes and
// emits a CRC-protected report frame when a change, a timeout or the first
// item calls for it.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  s_*      | in        | s_tvalid/s_tready  | tdata readings+flags+minute, tuser motion_valid
//  m_*      | out       | m_tvalid/m_tready  | tdata frame_byte, tlast frame_last
//  cfg_*    | in        | cfg_we             | cfg_index, cfg_data
//
// An item passes through capture, lane products and decision. A reporting
// item then sends 33 or 38 frame bytes, one per cycle while m_tready is
// high; the next request is taken once the framer is idle while the final
// byte may still wait in the output register. Reset clears references and
// the last report minute and arms the first-item report. m_tready low holds
// the framer.
// ----------------------------------------------------------------------------
`default_nettype none

module change_triggered_sensor_frame_builder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [15:0] temperature_value, [31:16] humidity_value, [47:32] light_value,
	// [63:48] carbon_dioxide_value, [64] digital_input, [65] motion_value,
	// [66] vibration_value, [82:67] now_minutes, [87:83] zero
	input  wire logic [87:0] s_tdata,
	input  wire logic        s_tuser,   // [0] motion_valid
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [7:0] frame_byte
	output logic             m_tlast,   // frame_last
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_CALC   = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;

	logic [1:0]  state_q;
	logic [7:0]  node_id_q;
	logic [3:0]  delta_q;
	logic [15:0] interval_q;
	logic        first_q;
	logic [15:0] last_rep_q;

	logic [ctsfb_pkg::NUM_LANES-1:0][15:0] cur_q;
	logic        dig_q;
	logic        mot_q;
	logic        mot_ok_q;
	logic        vib_q;
	logic [15:0] now_q;

	logic        accept;
	logic        fr_busy;
	logic [ctsfb_pkg::NUM_LANES-1:0] lane_changed;
	logic [15:0] elapsed;
	logic        report;
	logic        commit;
	ctsfb_pkg::frame_req_t frame_req;

	assign s_tready = (state_q == ST_IDLE) && !fr_busy;
	assign accept   = s_tvalid && s_tready;
	assign commit   = (state_q == ST_DECIDE);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q  <= 8'd0;
			delta_q    <= 4'd0;
			interval_q <= ctsfb_pkg::INTERVAL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ctsfb_pkg::REG_NODE_ID:  node_id_q  <= cfg_data[7:0];
				ctsfb_pkg::REG_DELTA:    delta_q    <= cfg_data[3:0];
				ctsfb_pkg::REG_INTERVAL: interval_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q[0] <= s_tdata[15:0];
			cur_q[1] <= s_tdata[31:16];
			cur_q[2] <= s_tdata[47:32];
			cur_q[3] <= s_tdata[63:48];
			dig_q    <= s_tdata[64];
			mot_q    <= s_tdata[65];
			vib_q    <= s_tdata[66];
			now_q    <= s_tdata[82:67];
			mot_ok_q <= s_tuser;
		end
	end

	// change-detect lanes
	for (genvar g = 0; g < ctsfb_pkg::NUM_LANES; g++) begin : g_lane
		ctsfb_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.calc       (state_q == ST_CALC),
			.commit     (commit),
			.load_first (first_q),
			.delta      (delta_q),
			.cur        (cur_q[g]),
			.changed    (lane_changed[g])
		);
	end

	// merge: any lane change, timeout or first item
	assign elapsed = now_q - last_rep_q;
	assign report  = first_q || (|lane_changed) || (elapsed > interval_q);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			first_q    <= 1'b1;
			last_rep_q <= 16'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: state_q <= ST_DECIDE;
				ST_DECIDE: begin
					state_q <= ST_IDLE;
					first_q <= 1'b0;
					if (report) begin
						last_rep_q <= now_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// frame request
	always_comb begin
		frame_req.node_id         = node_id_q;
		frame_req.values          = cur_q;
		frame_req.digital_input   = dig_q;
		frame_req.motion_value    = mot_q;
		frame_req.motion_valid    = mot_ok_q;
		frame_req.vibration_value = vib_q;
	end

	ctsfb_framer u_framer (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (commit && report),
		.req      (frame_req),
		.busy     (fr_busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

[tb/ctsfb_frame_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctsfb_frame_checker
// Watches the configuration port and both streams of the sensor frame
// builder. It keeps its own copy of the references, the last report minute
// and the registers, works out the frame that each accepted request should
// produce and compares every output byte, in order, with that frame.
// ----------------------------------------------------------------------------
module ctsfb_frame_checker
	import ctsfb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [87:0] s_tdata,
	input  wire logic        s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [7:0]  m_tdata,
	input  wire logic        m_tlast,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	output int               errors,
	output int               pending
);

	localparam int MAX_REPORTS = 10;

	// group ports; the four readings use consecutive ports from the first one
	localparam logic [7:0] PORT_FIRST_LANE = 8'h01;
	localparam logic [7:0] PORT_DIGITAL    = 8'h05;
	localparam logic [7:0] PORT_MOTION     = 8'h06;
	localparam logic [7:0] PORT_VIBRATION  = 8'h07;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_beat_t;

	logic [7:0]  node_reg;
	logic [3:0]  delta_reg;
	logic [15:0] interval_reg;
	logic [15:0] baseline [NUM_LANES];
	logic [15:0] last_report_min;
	logic        awaiting_first;
	logic [15:0] frame_crc;
	frame_beat_t frame_q [$];
	int          err_count = 0;

	// CRC-16, reflected, one byte
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	// signed percent change, truncated toward zero; a zero reading always counts
	function automatic bit reading_moved(input logic [15:0] base, input logic [15:0] cur,
			input logic [3:0] thr);
		int pct;
		int lim;
		if (cur == 16'h0000)
			return 1'b1;
		lim = int'(thr);
		pct = ((int'(base) - int'(cur)) * PERCENT_SCALE) / int'(cur);
		return (pct > lim) || (pct < -lim);
	endfunction

	task automatic push_data(input logic [7:0] b);
		frame_crc = crc16_byte(frame_crc, b);
		frame_q.push_back(frame_beat_t'{b, 1'b0});
	endtask

	task automatic push_group(input logic [7:0] port, input logic [15:0] value,
			input logic [7:0] kind);
		push_data(8'h00);
		push_data(port);
		push_data(value[15:8]);
		push_data(value[7:0]);
		push_data(kind);
	endtask

	// decide whether a request reports and queue its frame bytes
	task automatic predict_frame(input logic [87:0] item, input logic motion_ok);
		logic [15:0] reading [NUM_LANES];
		logic [15:0] now_min;
		logic [15:0] elapsed;
		logic        report;
		for (int i = 0; i < NUM_LANES; i++)
			reading[i] = item[16*i +: 16];
		now_min = item[82:67];
		report = awaiting_first;

		// first request loads the references
		if (awaiting_first) begin
			for (int i = 0; i < NUM_LANES; i++)
				baseline[i] = reading[i];
			awaiting_first = 1'b0;
		end

		if (delta_reg != 4'h0) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				if (reading_moved(baseline[i], reading[i], delta_reg)) begin
					baseline[i] = reading[i];
					report = 1'b1;
				end
			end
		end

		// elapsed minutes wrap with the counter
		elapsed = now_min - last_report_min;
		if (elapsed > interval_reg)
			report = 1'b1;

		if (report) begin
			last_report_min = now_min;
			frame_crc = CRC_INIT;
			push_data(node_reg);
			for (int i = 0; i < NUM_LANES; i++)
				push_group(PORT_FIRST_LANE + 8'(i), reading[i], TYPE_INTEGER);
			push_group(PORT_DIGITAL, {15'h0000, item[64]}, TYPE_BOOLEAN);
			if (motion_ok)
				push_group(PORT_MOTION, {15'h0000, item[65]}, TYPE_BOOLEAN);
			push_group(PORT_VIBRATION, {15'h0000, item[66]}, TYPE_BOOLEAN);
			// CRC goes out high byte first and is not fed back
			frame_q.push_back(frame_beat_t'{frame_crc[15:8], 1'b0});
			frame_q.push_back(frame_beat_t'{frame_crc[7:0], 1'b1});
		end
	endtask

	task automatic check_byte(input logic [7:0] got_data, input logic got_last);
		frame_beat_t want;
		if (frame_q.size() == 0) begin
			if (err_count < MAX_REPORTS)
				$display("%0t: unexpected frame byte %02h last %0b", $time, got_data, got_last);
			err_count++;
		end else begin
			want = frame_q.pop_front();
			if (got_data !== want.data || got_last !== want.last) begin
				if (err_count < MAX_REPORTS)
					$display("%0t: frame byte mismatch: expected %02h last %0b, got %02h last %0b",
						$time, want.data, want.last, got_data, got_last);
				err_count++;
			end
		end
	endtask

	// model state follows the block at every edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_reg = 8'h00;
			delta_reg = 4'h0;
			interval_reg = INTERVAL_RESET;
			for (int i = 0; i < NUM_LANES; i++)
				baseline[i] = 16'h0000;
			last_report_min = 16'h0000;
			awaiting_first = 1'b1;
			frame_crc = CRC_INIT;
			frame_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_NODE_ID: begin
						node_reg = cfg_data[7:0];
					end
					REG_DELTA: begin
						delta_reg = cfg_data[3:0];
					end
					REG_INTERVAL: begin
						interval_reg = cfg_data;
					end
					default: begin
						// no register behind this index
					end
				endcase
			end
			if (s_tvalid && s_tready)
				predict_frame(s_tdata, s_tuser);
			if (m_tvalid && m_tready)
				check_byte(m_tdata, m_tlast);
		end
		pending = frame_q.size();
		errors = err_count;
	end

endmodule

[tb/tb_change_triggered_sensor_frame_builder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_change_triggered_sensor_frame_builder
// Drives sensor reading sets into the frame builder: a directed part for the
// first item, the interval boundary, minute wrap, zero readings and threshold
// edges, then random runs under several register settings. The sender works
// in bursts, the receiver stalls on its own pattern and once holds off long
// enough to back up the input. The checker beside the block does the
// prediction and comparison.
// ----------------------------------------------------------------------------
module tb_change_triggered_sensor_frame_builder;
	import ctsfb_pkg::*;

	localparam int QUIET_LIMIT   = 3000;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES   = 400;
	localparam int RUN_ITEMS     = 80;

	// index with no register behind it
	localparam logic [1:0] REG_UNUSED = 2'd3;

	// receiver stall patterns
	localparam int SINK_OPEN     = 0;
	localparam int SINK_COIN     = 1;
	localparam int SINK_SPARSE   = 2;
	localparam int SINK_PERIODIC = 3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [87:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = 2'd0;
	logic [15:0] cfg_data = 16'h0000;

	int          errors;
	int          pending;
	int          hold_requests = 0;
	int          burst_left = 0;
	logic [15:0] level [NUM_LANES];
	logic [15:0] clock_min;
	logic [15:0] cur_interval;

	always #5 clk = ~clk;

	change_triggered_sensor_frame_builder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ctsfb_frame_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	// offer one reading set, opening a gap first when the burst is used up
	task automatic offer_reading(input logic [15:0] t, input logic [15:0] h,
			input logic [15:0] l, input logic [15:0] c, input logic dig, input logic mot,
			input logic vib, input logic [15:0] now_min, input logic motion_ok);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b00000, now_min, vib, mot, dig, c, l, h, t};
		s_tuser <= motion_ok;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		burst_left--;
		level[0] = t;
		level[1] = h;
		level[2] = l;
		level[3] = c;
		clock_min = now_min;
	endtask

	// stop sending and wait until every frame byte is out and the block is idle
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all three registers, junk in the unused upper bits
	task automatic program_regs(input logic [7:0] nid, input logic [3:0] thr,
			input logic [15:0] iv);
		cfg_we <= 1'b1;
		cfg_index <= REG_NODE_ID;
		cfg_data <= {8'($urandom), nid};
		@(posedge clk);
		cfg_index <= REG_DELTA;
		cfg_data <= {12'($urandom), thr};
		@(posedge clk);
		cfg_index <= REG_INTERVAL;
		cfg_data <= iv;
		@(posedge clk);
		// must be ignored
		cfg_index <= REG_UNUSED;
		cfg_data <= 16'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_interval = iv;
	endtask

	// random reading sets: mostly small drifts, some jumps, zeros and extremes
	task automatic random_run(input int count, input int hold_at);
		logic [15:0] reading [NUM_LANES];
		logic [15:0] span;
		logic [15:0] step;
		bit          quiet;
		int          pick;
		for (int k = 0; k < count; k++) begin
			if (k == hold_at)
				hold_requests <= hold_requests + 1;
			quiet = ($urandom_range(0, 1) == 0);
			for (int i = 0; i < NUM_LANES; i++) begin
				pick = quiet ? 0 : $urandom_range(0, 99);
				span = level[i] >> $urandom_range(2, 10);
				if (pick < 60)
					reading[i] = $urandom_range(0, 1) ? level[i] + 16'($urandom_range(0, span))
						: level[i] - 16'($urandom_range(0, span));
				else if (pick < 85)
					reading[i] = 16'($urandom);
				else if (pick < 90)
					reading[i] = 16'h0000;
				else if (pick < 95)
					reading[i] = 16'hFFFF;
				else
					reading[i] = 16'($urandom_range(1, 8));
			end
			// minute steps cluster around the interval boundary
			pick = $urandom_range(0, 99);
			if (pick < 45)
				step = 16'($urandom_range(0, 2));
			else if (pick < 75)
				step = cur_interval + 16'($urandom_range(0, 2)) - 16'd1;
			else if (pick < 90)
				step = 16'($urandom_range(0, 64));
			else
				step = 16'($urandom);
			offer_reading(reading[0], reading[1], reading[2], reading[3], 1'($urandom),
				1'($urandom), 1'($urandom), clock_min + step, 1'($urandom));
		end
	endtask

	// receiver: changing stall patterns, plus long hold-offs on request
	initial begin : sink
		int mode;
		int mode_left;
		int served;
		int hold_left;
		int tick;
		mode = SINK_OPEN;
		mode_left = 0;
		served = 0;
		hold_left = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_left == 0 && served != hold_requests) begin
				served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(SINK_OPEN, SINK_PERIODIC);
					mode_left = $urandom_range(32, 256);
				end
				mode_left--;
				case (mode)
					SINK_OPEN: begin
						m_tready <= 1'b1;
					end
					SINK_COIN: begin
						m_tready <= 1'($urandom);
					end
					SINK_SPARSE: begin
						m_tready <= ($urandom_range(0, 3) == 0);
					end
					default: begin
						m_tready <= (tick % 5 != 0);
					end
				endcase
			end
		end
	end

	// ends the run when nothing moves for too long
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : stimulus
		for (int i = 0; i < NUM_LANES; i++)
			level[i] = 16'h0000;
		clock_min = 16'h0000;
		cur_interval = INTERVAL_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: first item, interval boundary, minute wrap
		offer_reading(16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 1'b1, 1'b1, 1'b1, 16'h0005, 1'b1);
		offer_reading(16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 1'b0, 1'b0, 1'b0, 16'h0014, 1'b1);
		offer_reading(16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 1'b1, 1'b0, 1'b1, 16'h0015, 1'b0);
		offer_reading(16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 1'b0, 1'b1, 1'b0, 16'hFFFA, 1'b1);
		offer_reading(16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 1'b1, 1'b1, 1'b0, 16'h0009, 1'b1);
		offer_reading(16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 1'b0, 1'b0, 1'b1, 16'h000A, 1'b0);
		settle();

		// widest threshold, interval never expires: zero reading, large and small changes
		program_regs(8'hFF, 4'hF, 16'hFFFF);
		offer_reading(16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 1'b1, 1'b1, 1'b1, 16'h000B, 1'b1);
		offer_reading(16'hFFFF, 16'h03E8, 16'h8000, 16'h0001, 1'b0, 1'b1, 1'b1, 16'h000B, 1'b1);
		offer_reading(16'hF000, 16'h044C, 16'h8000, 16'h0001, 1'b1, 1'b0, 1'b0, 16'h000B, 1'b1);
		offer_reading(16'hF000, 16'h044C, 16'h8000, 16'h0002, 1'b0, 1'b1, 1'b0, 16'h000B, 1'b0);
		offer_reading(16'hF000, 16'h044C, 16'h0000, 16'h0002, 1'b1, 1'b1, 1'b1, 16'h000B, 1'b1);
		settle();

		// one percent threshold, zero interval
		program_regs(8'h5A, 4'h1, 16'h0000);
		offer_reading(16'hFFFF, 16'h03E8, 16'h01F4, 16'h0002, 1'b0, 1'b0, 1'b0, 16'h000B, 1'b0);
		offer_reading(16'hFFFF, 16'h03E8, 16'h01F4, 16'h0002, 1'b1, 1'b0, 1'b1, 16'h000B, 1'b1);
		offer_reading(16'hFFFF, 16'h03E8, 16'h01F4, 16'h0002, 1'b0, 1'b1, 1'b0, 16'h000C, 1'b1);
		offer_reading(16'hFD00, 16'h03E8, 16'h01F4, 16'h0002, 1'b1, 1'b1, 1'b1, 16'h000C, 1'b1);
		offer_reading(16'hF800, 16'h03E8, 16'h01F4, 16'h0002, 1'b0, 1'b0, 1'b1, 16'h000C, 1'b0);
		offer_reading(16'hF800, 16'h03E8, 16'h01F4, 16'h0003, 1'b1, 1'b0, 1'b0, 16'h000C, 1'b1);
		settle();

		// random runs under several settings
		program_regs(8'h00, 4'h0, INTERVAL_RESET);
		random_run(RUN_ITEMS, -1);
		settle();
		program_regs(8'($urandom), 4'hF, 16'hFFFF);
		random_run(RUN_ITEMS, -1);
		settle();
		// this run includes the long receiver hold-off
		program_regs(8'($urandom), 4'h5, 16'($urandom_range(0, 40)));
		random_run(RUN_ITEMS, 20);
		settle();
		program_regs(8'hFF, 4'h1, 16'h0000);
		random_run(RUN_ITEMS, -1);
		settle();
		program_regs(8'($urandom), 4'($urandom_range(2, 14)), 16'($urandom));
		random_run(RUN_ITEMS, -1);
		settle();

		if (errors == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[filelist.f]
src/ctsfb_pkg.sv
src/ctsfb_lane.sv
src/ctsfb_framer.sv
src/change_triggered_sensor_frame_builder.sv
tb/ctsfb_frame_checker.sv
tb/tb_change_triggered_sensor_frame_builder.sv
